// File: hw/rtl/sandpile_toppling_grid_macros.svh
// Assertion macros used by the sandpile grid checker.
`ifndef SANDPILE_TOPPLING_GRID_MACROS_SVH
`define SANDPILE_TOPPLING_GRID_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled in reset.
`define SPG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sandpile grid check failed");

// Next-cycle implication, sampled on clk, disabled in reset.
`define SPG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sandpile grid check failed");

`endif

// File: hw/rtl/spg_pkg.sv
// Shared constants, codes and control types of the sandpile grid.
`default_nettype none

package spg_pkg;

  // Grid geometry
  localparam int GRID_SIZE = 64;
  localparam int ROW_W     = 6;
  localparam int ADDR_W    = 2 * ROW_W;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;

  // Field widths
  localparam int OP_W  = 2;
  localparam int VAL_W = 31;
  localparam int CNT_W = 12;

  // Sweep scan: write-back lags the topple detection by one row plus one cell
  localparam int LAG            = GRID_SIZE + 1;
  localparam int SCAN_FEED_LAST = CELLS + GRID_SIZE;
  localparam int SCAN_LAST      = SCAN_FEED_LAST + 3;
  localparam int POS_W          = $clog2(SCAN_LAST + 1);

  // Topple-flag line: entry k holds the flag of the cell k+1 behind the newest
  localparam int TSR_LEN   = 2 * GRID_SIZE + 1;
  localparam int TAP_DOWN  = 0;
  localparam int TAP_RIGHT = GRID_SIZE - 1;
  localparam int TAP_SELF  = GRID_SIZE;
  localparam int TAP_LEFT  = GRID_SIZE + 1;
  localparam int TAP_UP    = 2 * GRID_SIZE;

  localparam logic [VAL_W-1:0] CELL_MAX  = '1;
  localparam logic [VAL_W-1:0] TOPPLE_AT = VAL_W'(4);
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [ROW_W-1:0] EDGE_LAST = ROW_W'(GRID_SIZE - 1);

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_SWEEP = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_UPDATE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic clear_en;
    logic load_item;
    logic scan_en;
    logic rd_item;
    logic update;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/spg_req_if.sv
// Request channel: one operation beat per item.
`default_nettype none

interface spg_req_if;
  logic                            valid;
  logic                            ready;
  logic [spg_pkg::OP_W-1:0]        operation;
  logic [spg_pkg::ROW_W-1:0]       row;
  logic [spg_pkg::ROW_W-1:0]       col;
  logic [spg_pkg::VAL_W-1:0]       amount;

  modport source (output valid, operation, row, col, amount, input ready);
  modport sink   (input valid, operation, row, col, amount, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/spg_rsp_if.sv
// Response channel: one result beat per item.
`default_nettype none

interface spg_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [spg_pkg::VAL_W-1:0]       cell_value;
  logic [spg_pkg::CNT_W-1:0]       toppled_count;

  modport source (output valid, cell_value, toppled_count, input ready);
  modport sink   (input valid, cell_value, toppled_count, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/spg_ctrl.sv
// Controller state machine of the sandpile grid.
`default_nettype none

module spg_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  req_valid,
  input  spg_pkg::op_t         req_op,
  output logic                 req_ready,
  output spg_pkg::dp_cmd_t     cmd,
  input  spg_pkg::dp_status_t  status
);

  spg_pkg::state_t state;
  spg_pkg::state_t state_next;

  // Hold state; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spg_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sequence each item and drive datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      spg_pkg::ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_last) begin
          state_next = spg_pkg::ST_IDLE;
        end
      end
      spg_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_item = 1'b1;
          unique case (req_op) inside
            spg_pkg::OP_ADD, spg_pkg::OP_READ: state_next = spg_pkg::ST_READ;
            spg_pkg::OP_SWEEP:                 state_next = spg_pkg::ST_SWEEP;
            default:                           state_next = spg_pkg::ST_RESP;
          endcase
        end
      end
      spg_pkg::ST_SWEEP: begin
        cmd.scan_en = 1'b1;
        if (status.scan_last) begin
          state_next = spg_pkg::ST_READ;
        end
      end
      spg_pkg::ST_READ: begin
        cmd.rd_item = 1'b1;
        state_next  = spg_pkg::ST_UPDATE;
      end
      spg_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = spg_pkg::ST_RESP;
      end
      spg_pkg::ST_RESP: begin
        if (status.out_free) begin
          cmd.push   = 1'b1;
          state_next = spg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spg_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/spg_datapath.sv
// Datapath of the sandpile grid: cell memory, sweep pipeline, result register.
`default_nettype none

module spg_datapath (
  input  wire                               clk,
  input  wire                               rst,
  input  spg_pkg::dp_cmd_t                  cmd,
  output spg_pkg::dp_status_t               status,
  input  wire [spg_pkg::OP_W-1:0]           operation,
  input  wire [spg_pkg::ROW_W-1:0]          row,
  input  wire [spg_pkg::ROW_W-1:0]          col,
  input  wire [spg_pkg::VAL_W-1:0]          amount,
  input  wire                               out_ready,
  output logic                              out_valid,
  output logic [spg_pkg::VAL_W-1:0]         cell_value,
  output logic [spg_pkg::CNT_W-1:0]         toppled_count
);

  localparam int VW = spg_pkg::VAL_W;
  localparam int AW = spg_pkg::ADDR_W;
  localparam int PW = spg_pkg::POS_W;
  localparam int RW = spg_pkg::ROW_W;

  // Latched item
  spg_pkg::op_t    op_q;
  logic [AW-1:0]   addr_q;
  logic [VW-1:0]   amount_q;

  // Scan / clear position
  logic [PW-1:0]   pos;

  // Cell memory and its read registers
  logic [VW-1:0]   mem [spg_pkg::CELLS];
  logic [VW-1:0]   rd_a;
  logic [VW-1:0]   rd_b;
  logic            rd_a_en;
  logic [AW-1:0]   rd_a_addr;
  logic [AW-1:0]   rd_b_addr;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [VW-1:0]   mem_wdata;

  // Sweep pipeline
  logic                       rd_vld;
  logic [PW-1:0]              rd_pos;
  logic [spg_pkg::TSR_LEN-1:0] tsr;
  logic                       t_new;
  logic                       q_ok;
  logic                       interior;
  logic [RW-1:0]              p_row;
  logic [RW-1:0]              p_col;
  logic                       s1_vld;
  logic [VW-1:0]              s1_old;
  logic [1:0]                 s1_b;
  logic [1:0]                 s1_a;
  logic                       s1_t;
  logic [AW-1:0]              s1_addr;
  logic                       s2_vld;
  logic [VW-1:0]              s2_val;
  logic [1:0]                 s2_a;
  logic                       s2_t;
  logic [AW-1:0]              s2_addr;
  logic [VW:0]                s1_sum;
  logic [VW-1:0]              s2_val_next;
  logic [VW:0]                s2_sum;
  logic [VW:0]                s2_less;
  logic [VW-1:0]              cell_new;
  logic [spg_pkg::CNT_W-1:0]  count;

  // Item update
  logic [VW:0]     add_sum;
  logic [VW-1:0]   add_sat;
  logic [VW-1:0]   res_value;

  // Latch the item on accept
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q     <= spg_pkg::op_t'(operation);
      addr_q   <= {row, col};
      amount_q <= amount;
    end
  end

  // Advance the position counter for clearing and sweeping
  always_ff @(posedge clk) begin
    if (rst || cmd.load_item) begin
      pos <= '0;
    end else if (cmd.clear_en || cmd.scan_en) begin
      pos <= pos + 1'b1;
    end
  end

  // Report pass ends and output room
  always_comb begin
    status.clear_last = (pos == PW'(spg_pkg::CELLS - 1));
    status.scan_last  = (pos == PW'(spg_pkg::SCAN_LAST));
    status.out_free   = !out_valid || out_ready;
  end

  // Pick memory addresses and write data
  always_comb begin
    rd_a_en   = cmd.rd_item || (cmd.scan_en && (pos < PW'(spg_pkg::CELLS)));
    rd_a_addr = cmd.rd_item ? addr_q : pos[AW-1:0];
    rd_b_addr = AW'(pos - PW'(spg_pkg::LAG));
    mem_we    = 1'b0;
    mem_waddr = s2_addr;
    mem_wdata = cell_new;
    if (cmd.clear_en) begin
      mem_we    = 1'b1;
      mem_waddr = pos[AW-1:0];
      mem_wdata = '0;
    end else if (cmd.update && (op_q == spg_pkg::OP_ADD)) begin
      mem_we    = 1'b1;
      mem_waddr = addr_q;
      mem_wdata = add_sat;
    end else if (s2_vld) begin
      mem_we    = 1'b1;
    end
  end

  // Cell memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_a_en) begin
      rd_a <= mem[rd_a_addr];
    end
    if (cmd.scan_en) begin
      rd_b <= mem[rd_b_addr];
    end
  end

  // Detect topple of the freshly read cell; find whether a write-back is due
  always_comb begin
    p_row    = rd_pos[AW-1:RW];
    p_col    = rd_pos[RW-1:0];
    interior = (p_row != '0) && (p_row != spg_pkg::EDGE_LAST) &&
               (p_col != '0) && (p_col != spg_pkg::EDGE_LAST);
    t_new    = (rd_pos < PW'(spg_pkg::CELLS)) && interior &&
               (rd_a >= spg_pkg::TOPPLE_AT);
    q_ok     = (rd_pos >= PW'(spg_pkg::LAG)) &&
               (rd_pos <= PW'(spg_pkg::SCAN_FEED_LAST));
  end

  // Stage 0 valid and position
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      rd_pos <= pos;
    end
  end

  // Shift topple flags and count topples
  always_ff @(posedge clk) begin
    if (rst || cmd.load_item) begin
      tsr   <= '0;
      count <= '0;
    end else if (rd_vld) begin
      tsr <= {tsr[spg_pkg::TSR_LEN-2:0], t_new};
      if (t_new && (count != spg_pkg::COUNT_MAX)) begin
        count <= count + 1'b1;
      end
    end
  end

  // Stage 1: gather neighbor flags of the lagging cell
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= rd_vld && q_ok;
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_old  <= rd_b;
    s1_b    <= {1'b0, tsr[spg_pkg::TAP_UP]} + {1'b0, tsr[spg_pkg::TAP_LEFT]};
    s1_a    <= {1'b0, tsr[spg_pkg::TAP_RIGHT]} + {1'b0, tsr[spg_pkg::TAP_DOWN]};
    s1_t    <= tsr[spg_pkg::TAP_SELF];
    s1_addr <= AW'(rd_pos - PW'(spg_pkg::LAG));
  end

  // Stage 2: add grains from neighbors scanned earlier, saturating
  always_comb begin
    s1_sum      = {1'b0, s1_old} + (VW + 1)'(s1_b);
    s2_val_next = s1_sum[VW] ? spg_pkg::CELL_MAX : s1_sum[VW-1:0];
  end

  always_ff @(posedge clk) begin
    s2_val  <= s2_val_next;
    s2_a    <= s1_a;
    s2_t    <= s1_t;
    s2_addr <= s1_addr;
  end

  // Stage 3: drop four if toppled, add grains from later neighbors
  always_comb begin
    s2_sum  = {1'b0, s2_val} + (VW + 1)'(s2_a);
    s2_less = s2_sum - (VW + 1)'(spg_pkg::TOPPLE_AT);
    if (s2_t) begin
      cell_new = s2_less[VW-1:0];
    end else begin
      cell_new = s2_sum[VW] ? spg_pkg::CELL_MAX : s2_sum[VW-1:0];
    end
  end

  // Saturating add for an add item
  always_comb begin
    add_sum = {1'b0, rd_a} + {1'b0, amount_q};
    add_sat = add_sum[VW] ? spg_pkg::CELL_MAX : add_sum[VW-1:0];
  end

  // Hold the addressed cell value for the result
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      res_value <= '0;
    end else if (cmd.update) begin
      res_value <= (op_q == spg_pkg::OP_ADD) ? add_sat : rd_a;
    end
  end

  // Output register: load on push, drop on accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      cell_value    <= res_value;
      toppled_count <= count;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sandpile_toppling_grid.sv
// Add and read run from accept through the read, update and response states; an unused code
// goes straight to the response state. A sweep first scans, one cell read per cycle over the
// 64x64 memory with a write-back lag of one row plus one cell, then reads the addressed cell.
// The result is pushed once the output register has room; a new item is
// taken while the previous result still waits in the output register.
// Reset: a clearing pass writes zero to all 4096 cells; no item is taken.
`default_nettype none

module sandpile_toppling_grid (
  input  wire        clk,
  input  wire        rst,
  spg_req_if.sink    req,
  spg_rsp_if.source  rsp
);

  spg_pkg::dp_cmd_t     cmd;
  spg_pkg::dp_status_t  status;
  logic                 req_ready;
  logic                 rsp_valid;
  logic [spg_pkg::VAL_W-1:0] rsp_cell_value;
  logic [spg_pkg::CNT_W-1:0] rsp_toppled_count;

  // Sequence items
  spg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (spg_pkg::op_t'(req.operation)),
    .req_ready (req_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Store and sweep the grid
  spg_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .operation     (req.operation),
    .row           (req.row),
    .col           (req.col),
    .amount        (req.amount),
    .out_ready     (rsp.ready),
    .out_valid     (rsp_valid),
    .cell_value    (rsp_cell_value),
    .toppled_count (rsp_toppled_count)
  );

  assign req.ready         = req_ready;
  assign rsp.valid         = rsp_valid;
  assign rsp.cell_value    = rsp_cell_value;
  assign rsp.toppled_count = rsp_toppled_count;

endmodule

`default_nettype wire

// File: hw/rtl/spg_checker.sv
// Port-level checks of the sandpile grid, bound to its top level.
`default_nettype none
`include "sandpile_toppling_grid_macros.svh"

module spg_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          req_valid,
  input wire                          req_ready,
  input wire                          rsp_valid,
  input wire                          rsp_ready,
  input wire [spg_pkg::VAL_W-1:0]     rsp_cell_value,
  input wire [spg_pkg::CNT_W-1:0]     rsp_toppled_count
);

  logic [1:0] pending;
  logic       req_beat;
  logic       rsp_beat;
  logic [spg_pkg::VAL_W+spg_pkg::CNT_W-1:0] rsp_data;

  assign req_beat = req_valid && req_ready;
  assign rsp_beat = rsp_valid && rsp_ready;
  assign rsp_data = {rsp_cell_value, rsp_toppled_count};

  // Track items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, req_beat} - {1'b0, rsp_beat};
    end
  end

  `SPG_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
  `SPG_ASSERT_NOW(a_one_waiting, req_beat, pending <= 2'd1)
  `SPG_ASSERT_NOW(a_count_range, rsp_valid, rsp_toppled_count <= 12'd3844)
  `SPG_ASSERT_NOW(a_clear_after_reset, $fell(rst), !req_ready && !rsp_valid)

endmodule

bind sandpile_toppling_grid spg_checker u_spg_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_cell_value    (rsp.cell_value),
  .rsp_toppled_count (rsp.toppled_count)
);

`default_nettype wire
